// ===== rtl/core/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared constants and types of the repetition code decoder: register
// indexes, decode modes, accumulator width and the per-request tag.
// ----------------------------------------------------------------------------
package rcd_pkg;

	// Default sizing of the block.
	localparam int MAX_BITS_DEF  = 256;
	localparam int MAX_REPS_DEF  = 64;
	localparam int LLR_WIDTH_DEF = 8;

	// Configuration port layout.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int BPF_W      = 9;
	localparam int REPS_W     = 7;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_FRAME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPETITIONS    = 2'd2;

	// Register reset values.
	localparam logic [BPF_W-1:0]  BPF_RESET  = 9'd64;
	localparam logic [REPS_W-1:0] REPS_RESET = 7'd3;

	// Decode modes.
	localparam logic MODE_HARD = 1'b0;
	localparam logic MODE_SOFT = 1'b1;

	// Accumulator format and saturation limits.
	localparam int SUM_W = 16;
	localparam logic signed [SUM_W-1:0] SUM_MAX = 16'sh7FFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 16'sh8000;

	// Output bit index width.
	localparam int BIT_INDEX_W = 8;

	// Frame position flags that travel with each request.
	typedef struct packed {
		logic first_rep;
		logic last_rep;
		logic last_bit;
	} rcd_tag_t;

endpackage

// ===== rtl/core/rcd_seq.sv =====
// ----------------------------------------------------------------------------
// rcd_seq
// Configuration registers and frame sequencer. Tracks the bit and
// repetition position of the next request and tags it with its flags.
// ----------------------------------------------------------------------------
module rcd_seq #(
	parameter int MAX_BITS = rcd_pkg::MAX_BITS_DEF,
	parameter int MAX_REPS = rcd_pkg::MAX_REPS_DEF,
	parameter int POS_W    = 8,
	parameter int REP_W    = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           advance,
	output logic [POS_W-1:0]               pos,
	output rcd_pkg::rcd_tag_t              tag,
	output logic                           mode
);

	logic                       mode_q;
	logic [rcd_pkg::BPF_W-1:0]  bpf_q;
	logic [rcd_pkg::REPS_W-1:0] reps_q;
	logic [POS_W-1:0]           pos_q;
	logic [REP_W-1:0]           rep_q;
	logic [31:0]                last_pos_w;
	logic [31:0]                last_rep_w;
	logic [POS_W-1:0]           last_pos;
	logic [REP_W-1:0]           last_rep;
	logic                       cfg_hit;

	// Effective frame length and repetition count, less one.
	always_comb begin
		if (bpf_q == '0) begin
			last_pos_w = 32'd0;
		end else if (32'(bpf_q) > 32'(MAX_BITS)) begin
			last_pos_w = 32'(MAX_BITS - 1);
		end else begin
			last_pos_w = 32'(bpf_q) - 32'd1;
		end
		if (reps_q == '0) begin
			last_rep_w = 32'd0;
		end else if (32'(reps_q) > 32'(MAX_REPS)) begin
			last_rep_w = 32'(MAX_REPS - 1);
		end else begin
			last_rep_w = 32'(reps_q) - 32'd1;
		end
	end

	assign last_pos = last_pos_w[POS_W-1:0];
	assign last_rep = last_rep_w[REP_W-1:0];

	// A write to a listed register restarts the frame.
	always_comb begin
		unique case (cfg_index)
			rcd_pkg::CFG_DECODE_MODE,
			rcd_pkg::CFG_BITS_PER_FRAME,
			rcd_pkg::CFG_REPETITIONS: cfg_hit = cfg_we;
			default:                  cfg_hit = 1'b0;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rcd_pkg::MODE_HARD;
			bpf_q  <= rcd_pkg::BPF_RESET;
			reps_q <= rcd_pkg::REPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rcd_pkg::CFG_DECODE_MODE:    mode_q <= cfg_data[0];
				rcd_pkg::CFG_BITS_PER_FRAME: bpf_q  <= cfg_data[rcd_pkg::BPF_W-1:0];
				rcd_pkg::CFG_REPETITIONS:    reps_q <= cfg_data[rcd_pkg::REPS_W-1:0];
				default: ;
			endcase
		end
	end

	// Position counters, stepped on every accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			rep_q <= '0;
		end else if (cfg_hit) begin
			pos_q <= '0;
			rep_q <= '0;
		end else if (advance) begin
			if (pos_q == last_pos) begin
				pos_q <= '0;
				rep_q <= (rep_q == last_rep) ? '0 : rep_q + 1'b1;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	assign pos           = pos_q;
	assign mode          = mode_q;
	assign tag.first_rep = (rep_q == '0);
	assign tag.last_rep  = (rep_q == last_rep);
	assign tag.last_bit  = (pos_q == last_pos);

endmodule

// ===== rtl/core/rcd_accum.sv =====
// ----------------------------------------------------------------------------
// rcd_accum
// Accumulator memory with read-modify-write stage, write forwarding and
// the result output register.
// ----------------------------------------------------------------------------
module rcd_accum #(
	parameter int MAX_BITS  = rcd_pkg::MAX_BITS_DEF,
	parameter int LLR_WIDTH = rcd_pkg::LLR_WIDTH_DEF,
	parameter int POS_W     = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_fire,
	input  logic signed [LLR_WIDTH-1:0]      llr,
	input  logic [POS_W-1:0]                 pos,
	input  rcd_pkg::rcd_tag_t                tag,
	input  logic                             mode,
	output logic                             in_ready,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             decoded_bit,
	output logic [rcd_pkg::BIT_INDEX_W-1:0]  bit_index,
	output logic                             last_of_frame
);

	localparam int SW = rcd_pkg::SUM_W;

	// Accumulator storage.
	logic signed [SW-1:0] mem [MAX_BITS];

	logic                        s1_valid;
	logic signed [LLR_WIDTH-1:0] llr_s1;
	logic [POS_W-1:0]            pos_s1;
	rcd_pkg::rcd_tag_t           tag_s1;
	logic signed [SW-1:0]        rd_data_s1;

	logic                        fwd_valid_q;
	logic [POS_W-1:0]            fwd_pos_q;
	logic signed [SW-1:0]        fwd_data_q;

	logic                        out_valid_q;
	logic                        bit_s2;
	logic [rcd_pkg::BIT_INDEX_W-1:0] index_s2;
	logic                        last_s2;

	logic                        fwd_hit;
	logic signed [SW-1:0]        contrib;
	logic signed [SW-1:0]        old_sum;
	logic signed [SW:0]          sum_wide;
	logic signed [SW-1:0]        acc;
	logic                        dec_bit;
	logic                        s1_fire;
	logic                        wr_en;
	logic [31:0]                 pos_wide;

	// Stage 1 completes when its result, if any, has room in the output register.
	assign s1_fire  = s1_valid && (!tag_s1.last_rep || !out_valid_q || out_ready);
	assign in_ready = !s1_valid || s1_fire;
	assign wr_en    = s1_fire;

	// Memory read on accept, write back when stage 1 completes.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_data_s1 <= mem[pos];
		end
		if (wr_en) begin
			mem[pos_s1] <= acc;
		end
	end

	// Stage 1 request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_fire) begin
			s1_valid <= 1'b1;
		end else if (s1_fire) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			llr_s1 <= llr;
			pos_s1 <= pos;
			tag_s1 <= tag;
		end
	end

	// The last write is kept to cover a read issued in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_pos_q  <= pos_s1;
			fwd_data_q <= acc;
		end
	end

	// Contribution, accumulate with saturation and decision.
	always_comb begin
		if (mode == rcd_pkg::MODE_HARD) begin
			contrib = llr_s1[LLR_WIDTH-1] ? -16'sd1 : 16'sd1;
		end else begin
			contrib = SW'(llr_s1);
		end
		fwd_hit  = fwd_valid_q && (fwd_pos_q == pos_s1);
		old_sum  = fwd_hit ? fwd_data_q : rd_data_s1;
		sum_wide = (SW+1)'(old_sum) + (SW+1)'(contrib);
		if (tag_s1.first_rep) begin
			acc = contrib;
		end else if (sum_wide[SW] != sum_wide[SW-1]) begin
			acc = sum_wide[SW] ? rcd_pkg::SUM_MIN : rcd_pkg::SUM_MAX;
		end else begin
			acc = sum_wide[SW-1:0];
		end
		if (mode == rcd_pkg::MODE_HARD) begin
			dec_bit = acc[SW-1] || (acc == '0);
		end else begin
			dec_bit = acc[SW-1];
		end
		pos_wide = 32'(pos_s1);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && tag_s1.last_rep) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && tag_s1.last_rep) begin
			bit_s2   <= dec_bit;
			index_s2 <= pos_wide[rcd_pkg::BIT_INDEX_W-1:0];
			last_s2  <= tag_s1.last_bit;
		end
	end

	assign out_valid     = out_valid_q;
	assign decoded_bit   = bit_s2;
	assign bit_index     = index_s2;
	assign last_of_frame = last_s2;

	// A stalled stage 1 keeps its request.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_fire |=> s1_valid && $stable(pos_s1) && $stable(llr_s1))
		else $error("stage 1 request changed while stalled");

	// A result never overwrites one that is still waiting.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && tag_s1.last_rep |-> !out_valid_q || out_ready)
		else $error("output register overrun");

	// No new request enters stage 1 while it is occupied and stalled.
	a_no_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> !s1_valid || s1_fire)
		else $error("request accepted into a busy stage");

	// A waiting result stays until taken.
	a_out_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(index_s2))
		else $error("result dropped before it was taken");

endmodule

// ===== rtl/core/repetition_code_decoder_top.sv =====
// ----------------------------------------------------------------------------
// repetition_code_decoder_top
// Repetition code decoder, hard majority vote or soft LLR sum.
// ----------------------------------------------------------------------------
// The decoder accepts one LLR sample per clock cycle in repetition-major
// order while the output register can take each decided bit; each sample
// costs one read-modify-write of the per-bit accumulator memory, which has
// one read and one write port, with the write of the previous sample
// forwarded for one-bit frames. A sample of the last repetition is held in
// the stage 1 register and its decided bit is then registered in the output
// register. Any write to a configuration register restarts the frame and
// must be made while the decoder is idle. There is no clearing pass after
// reset: the first repetition of every bit overwrites its accumulator.
// ----------------------------------------------------------------------------
module repetition_code_decoder_top #(
	parameter int MAX_BITS  = rcd_pkg::MAX_BITS_DEF,
	parameter int MAX_REPS  = rcd_pkg::MAX_REPS_DEF,
	parameter int LLR_WIDTH = rcd_pkg::LLR_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rcd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [LLR_WIDTH-1:0]      llr,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             decoded_bit,
	output logic [rcd_pkg::BIT_INDEX_W-1:0]  bit_index,
	output logic                             last_of_frame
);

	localparam int POS_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
	localparam int REP_W = (MAX_REPS > 1) ? $clog2(MAX_REPS) : 1;

	logic              in_fire;
	logic [POS_W-1:0]  pos;
	rcd_pkg::rcd_tag_t tag;
	logic              mode;

	assign in_fire = in_valid && in_ready;

	// Configuration and frame position.
	rcd_seq #(
		.MAX_BITS (MAX_BITS),
		.MAX_REPS (MAX_REPS),
		.POS_W    (POS_W),
		.REP_W    (REP_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (in_fire),
		.pos       (pos),
		.tag       (tag),
		.mode      (mode)
	);

	// Accumulation and decision.
	rcd_accum #(
		.MAX_BITS  (MAX_BITS),
		.LLR_WIDTH (LLR_WIDTH),
		.POS_W     (POS_W)
	) u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.llr           (llr),
		.pos           (pos),
		.tag           (tag),
		.mode          (mode),
		.in_ready      (in_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.decoded_bit   (decoded_bit),
		.bit_index     (bit_index),
		.last_of_frame (last_of_frame)
	);

endmodule

// ===== sim/repetition_code_decoder_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repetition_code_decoder_top_test
// Self-checking testbench of the repetition code decoder. A behavioral
// predictor follows every accepted LLR request and queues the decided bits
// it expects. Each decision the decoder delivers is compared field by field
// with the oldest queued one. Directed cases come first, then frames with
// random content and random register settings, with random idling on both
// channels and one long output hold-off.
// ----------------------------------------------------------------------------
module repetition_code_decoder_top_test;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int ITEM_TARGET   = 1900;
	localparam int IDLE_PCT      = 36;

	localparam int LLR_W   = rcd_pkg::LLR_WIDTH_DEF;
	localparam int INDEX_W = rcd_pkg::BIT_INDEX_W;
	localparam int DATA_W  = rcd_pkg::CFG_DATA_W;
	localparam int IDX_W   = rcd_pkg::CFG_IDX_W;

	// Index past the register list; a write there must change nothing.
	localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic               bit_value;
		logic [INDEX_W-1:0] index;
		logic               last_bit;
	} decision_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [IDX_W-1:0]         cfg_index;
	logic [DATA_W-1:0]        cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [LLR_W-1:0]  llr;
	logic                     out_valid;
	logic                     out_ready;
	logic                     decoded_bit;
	logic [INDEX_W-1:0]       bit_index;
	logic                     last_of_frame;

	// Predictor state: registers, accumulators and frame position.
	logic                          model_mode;
	logic [rcd_pkg::BPF_W-1:0]     model_bits;
	logic [rcd_pkg::REPS_W-1:0]    model_reps;
	int                            vote_acc [rcd_pkg::MAX_BITS_DEF];
	int                            frame_bit;
	int                            frame_rep;
	decision_t                     pending_decisions [$];

	int fail_count    = 0;
	int items_sent    = 0;
	int cycle_count   = 0;
	int hold_requests = 0;
	bit idling_on     = 1'b1;

	repetition_code_decoder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.llr          (llr),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.decoded_bit  (decoded_bit),
		.bit_index    (bit_index),
		.last_of_frame(last_of_frame)
	);

	always #4 clk = ~clk;

	// Effective frame length and repetition count after clamping.
	function automatic int active_bits();
		if (model_bits == 0) return 1;
		if (model_bits > rcd_pkg::MAX_BITS_DEF) return rcd_pkg::MAX_BITS_DEF;
		return int'(model_bits);
	endfunction

	function automatic int active_reps();
		if (model_reps == 0) return 1;
		if (model_reps > rcd_pkg::MAX_REPS_DEF) return rcd_pkg::MAX_REPS_DEF;
		return int'(model_reps);
	endfunction

	function automatic int clamp_sum(input int value);
		if (value > int'(rcd_pkg::SUM_MAX)) return int'(rcd_pkg::SUM_MAX);
		if (value < int'(rcd_pkg::SUM_MIN)) return int'(rcd_pkg::SUM_MIN);
		return value;
	endfunction

	// Accumulates one sample and queues a decision on the last repetition.
	function automatic void decode_sample(input logic signed [LLR_W-1:0] sample);
		int k;
		int reps;
		int pos;
		int contrib;
		int acc;
		logic bit_value;
		k = active_bits();
		reps = active_reps();
		pos = frame_bit;
		if (pos >= k) pos = 0;
		if (frame_rep >= reps) frame_rep = 0;
		if (model_mode == rcd_pkg::MODE_HARD) contrib = (sample >= 0) ? 1 : -1;
		else contrib = int'(sample);
		if (frame_rep == 0) acc = clamp_sum(contrib);
		else acc = clamp_sum(vote_acc[pos] + contrib);
		vote_acc[pos] = acc;
		if (frame_rep == reps - 1) begin
			if (model_mode == rcd_pkg::MODE_HARD) bit_value = (acc <= 0);
			else bit_value = (acc < 0);
			pending_decisions.push_back('{bit_value, INDEX_W'(pos), pos == k - 1});
		end
		pos++;
		if (pos >= k) begin
			pos = 0;
			frame_rep++;
			if (frame_rep >= reps) frame_rep = 0;
		end
		frame_bit = pos;
	endfunction

	function automatic logic signed [LLR_W-1:0] random_llr();
		case ($urandom_range(9))
			0: return -128;
			1: return 127;
			2, 3: return LLR_W'(int'($urandom_range(6)) - 3);
			default: return LLR_W'($urandom);
		endcase
	endfunction

	// One register write; listed registers also restart the frame.
	task automatic write_register(input logic [IDX_W-1:0] index,
			input logic [DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(posedge clk);
		case (index)
			rcd_pkg::CFG_DECODE_MODE: begin
				model_mode = data[0];
				frame_bit = 0;
				frame_rep = 0;
			end
			rcd_pkg::CFG_BITS_PER_FRAME: begin
				model_bits = data[rcd_pkg::BPF_W-1:0];
				frame_bit = 0;
				frame_rep = 0;
			end
			rcd_pkg::CFG_REPETITIONS: begin
				model_reps = data[rcd_pkg::REPS_W-1:0];
				frame_bit = 0;
				frame_rep = 0;
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_frame(input logic mode, input int bits, input int reps);
		write_register(rcd_pkg::CFG_DECODE_MODE, DATA_W'(mode));
		write_register(rcd_pkg::CFG_BITS_PER_FRAME, DATA_W'(bits));
		write_register(rcd_pkg::CFG_REPETITIONS, DATA_W'(reps));
	endtask

	// Offers one LLR request and returns once it has been accepted.
	task automatic send_llr(input logic signed [LLR_W-1:0] value);
		@(negedge clk);
		while (idling_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		llr = value;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_frame(input int count);
		repeat (count) send_llr(random_llr());
	endtask

	// Drops the request line and waits until every decision has arrived.
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_decisions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Output side: random stalls, plus a long hold-off on request.
	initial begin : receiver
		int hold_seen;
		int c;
		hold_seen = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				out_ready = 1'b0;
				for (c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
			end
			out_ready = !idling_on || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Predicts accepted requests and checks delivered decisions.
	always @(posedge clk) begin
		decision_t want;
		if (arst_n) begin
			if (in_valid && in_ready) decode_sample(llr);
			if (out_valid && out_ready) begin
				if (pending_decisions.size() == 0) begin
					$error("decision for bit_index %0d arrived with none expected", bit_index);
					fail_count++;
				end else begin
					want = pending_decisions.pop_front();
					if (decoded_bit !== want.bit_value) begin
						$error("decoded_bit: expected %0d, got %0d", want.bit_value, decoded_bit);
						fail_count++;
					end
					if (bit_index !== want.index) begin
						$error("bit_index: expected %0d, got %0d", want.index, bit_index);
						fail_count++;
					end
					if (last_of_frame !== want.last_bit) begin
						$error("last_of_frame: expected %0d, got %0d", want.last_bit,
							last_of_frame);
						fail_count++;
					end
				end
			end
		end
	end

	// Guard against a hung decoder.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// One frame with the register values left by reset.
	task automatic test_default_frame();
		send_frame(int'(rcd_pkg::BPF_RESET) * int'(rcd_pkg::REPS_RESET));
		wait_idle();
	endtask

	task automatic test_directed_cases();
		// Single-bit frames decide every sample on its own, including zero.
		set_frame(rcd_pkg::MODE_HARD, 1, 1);
		send_llr(127);
		send_llr(-128);
		send_llr(0);
		send_llr(-1);
		wait_idle();
		set_frame(rcd_pkg::MODE_SOFT, 1, 1);
		send_llr(127);
		send_llr(-128);
		send_llr(0);
		send_llr(-1);
		wait_idle();
		// A tied vote decides 1 in hard mode.
		set_frame(rcd_pkg::MODE_HARD, 2, 2);
		send_llr(5);
		send_llr(0);
		send_llr(-5);
		send_llr(0);
		wait_idle();
		// A zero sum decides 0 in soft mode, a sum of -1 decides 1.
		set_frame(rcd_pkg::MODE_SOFT, 2, 2);
		send_llr(127);
		send_llr(-5);
		send_llr(-128);
		send_llr(5);
		wait_idle();
		// Zero length and zero count both act as one.
		set_frame(rcd_pkg::MODE_HARD, 0, 0);
		send_llr(1);
		send_llr(-1);
		wait_idle();
		// Oversized settings; the partial frame is dropped by the next write.
		set_frame(rcd_pkg::MODE_SOFT, 9'h1FF, 7'h7F);
		send_llr(-128);
		send_llr(127);
		send_llr(0);
		wait_idle();
	endtask

	task automatic test_size_extremes();
		// Oversized length clamps to the largest frame.
		set_frame(rcd_pkg::MODE_HARD, 9'h1FF, 1);
		send_frame(rcd_pkg::MAX_BITS_DEF);
		wait_idle();
		// Oversized count clamps to the most repetitions.
		set_frame(rcd_pkg::MODE_SOFT, 1, 7'h7F);
		send_frame(rcd_pkg::MAX_REPS_DEF);
		wait_idle();
		set_frame(rcd_pkg::MODE_HARD, 3, rcd_pkg::MAX_REPS_DEF);
		send_frame(3 * rcd_pkg::MAX_REPS_DEF);
		wait_idle();
	endtask

	// The output stalls for a long stretch while requests keep coming.
	task automatic test_output_backpressure();
		set_frame(rcd_pkg::MODE_SOFT, 4, 1);
		idling_on = 1'b0;
		hold_requests++;
		send_frame(120);
		idling_on = 1'b1;
		wait_idle();
	endtask

	// Back-to-back requests with both sides always ready.
	task automatic test_full_rate();
		set_frame(rcd_pkg::MODE_HARD, 5, 3);
		idling_on = 1'b0;
		send_frame(60);
		wait_idle();
		idling_on = 1'b1;
	endtask

	// Random settings and whole frames, with some frames cut short.
	task automatic test_random_frames();
		int mode;
		int bits;
		int reps;
		int k;
		int r;
		int part;
		while (items_sent < ITEM_TARGET) begin
			mode = $urandom_range(1);
			case ($urandom_range(9))
				0: reps = $urandom_range(127, 65);
				1: reps = 0;
				2, 3: reps = $urandom_range(12, 5);
				default: reps = $urandom_range(4, 1);
			endcase
			r = (reps == 0) ? 1 :
				((reps > rcd_pkg::MAX_REPS_DEF) ? rcd_pkg::MAX_REPS_DEF : reps);
			if (r > 12) bits = $urandom_range(2);
			else begin
				case ($urandom_range(9))
					0: bits = 0;
					1, 2: bits = $urandom_range(40, 9);
					default: bits = $urandom_range(8, 1);
				endcase
			end
			k = (bits == 0) ? 1 : bits;
			// Upper data bits beyond a register's width are ignored.
			write_register(rcd_pkg::CFG_DECODE_MODE, {8'($urandom), 1'(mode)});
			write_register(rcd_pkg::CFG_BITS_PER_FRAME, DATA_W'(bits));
			write_register(rcd_pkg::CFG_REPETITIONS, {2'($urandom), 7'(reps)});
			send_frame($urandom_range(3, 1) * k * r);
			if (k * r > 1 && $urandom_range(3) == 0) begin
				part = $urandom_range(k * r - 1, 1);
				send_frame(part);
				wait_idle();
				// An unlisted index must not restart the frame.
				if ($urandom_range(1)) begin
					write_register(CFG_UNUSED, DATA_W'($urandom));
					send_frame(k * r - part);
				end
			end
			wait_idle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rcd_pkg::CFG_DECODE_MODE;
		cfg_data = '0;
		in_valid = 1'b0;
		llr = '0;
		model_mode = rcd_pkg::MODE_HARD;
		model_bits = rcd_pkg::BPF_RESET;
		model_reps = rcd_pkg::REPS_RESET;
		frame_bit = 0;
		frame_rep = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_default_frame();
		test_directed_cases();
		test_size_extremes();
		test_output_backpressure();
		test_full_rate();
		test_random_frames();

		wait_idle();
		if (fail_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
